>>> hw/rtl/dtpc_pkg.sv
// Shared types and constants for the depth-to-point back-projection pipeline.
// Used by dtpc_div and depth_to_point_cloud; no dependencies.
`default_nettype none

package dtpc_pkg;

  localparam logic [12:0] FRAME_WIDTH  = 13'd640;
  localparam logic [12:0] FRAME_HEIGHT = 13'd480;
  localparam logic [15:0] MAX_RANGE_MM = 16'd5000;

  // baseline*focal*1000 in Q.16, rounded
  localparam logic [31:0] DISP_K16 = 32'd2803346100;
  // baseline*focal in Q.40, rounded
  localparam logic [45:0] BF_Q40   = 46'd47032343042450;

  localparam logic [30:0] S32_MAX = 31'h7FFF_FFFF;

  // shared restoring divider geometry
  localparam int DIV_QW = 32;
  localparam int DIV_DW = 56;
  localparam int TAG_W  = 64;

  typedef enum logic [2:0] {
    CFG_PRINCIPAL_COL,
    CFG_PRINCIPAL_ROW,
    CFG_FOCAL_COL,
    CFG_FOCAL_ROW,
    CFG_DISPARITY_OFFSET,
    CFG_DISPARITY_GAIN,
    CFG_COL_SQ_COEFF,
    CFG_ROW_SQ_COEFF
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]  pixel_col;
    logic [8:0]  pixel_row;
    logic [15:0] raw_depth_mm;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               point_valid;
  } point_t;

  typedef struct packed {
    logic              vld;
    logic [DIV_DW-1:0] rem;   // must be below den
    logic [DIV_QW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic [TAG_W-1:0]  tag;
  } div_req_t;

  typedef struct packed {
    logic              vld;
    logic [DIV_QW-1:0] quo;
    logic [TAG_W-1:0]  tag;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/dtpc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on dtpc_pkg (geometry and request/response structs).
`default_nettype none

module dtpc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  dtpc_pkg::div_req_t req,
  output dtpc_pkg::div_rsp_t rsp
);
  import dtpc_pkg::*;

  logic [DIV_QW-1:0] vld_q;
  logic [DIV_DW-1:0] rem_q [0:DIV_QW-1];
  logic [DIV_QW-1:0] nq_q  [0:DIV_QW-1];
  logic [DIV_DW-1:0] den_q [0:DIV_QW-2];
  logic [TAG_W-1:0]  tag_q [0:DIV_QW-1];

  logic [DIV_DW-1:0] s_rem [0:DIV_QW-1];
  logic [DIV_QW-1:0] s_nq  [0:DIV_QW-1];
  logic [DIV_DW-1:0] s_den [0:DIV_QW-1];
  logic [TAG_W-1:0]  s_tag [0:DIV_QW-1];
  logic [DIV_DW:0]   trial [0:DIV_QW-1];
  logic [DIV_QW-1:0] ge;

  genvar k;
  generate
    for (k = 0; k < DIV_QW; k++) begin : g_stage
      if (k == 0) begin : g_first
        assign s_rem[k] = req.rem;
        assign s_nq[k]  = req.num;
        assign s_den[k] = req.den;
        assign s_tag[k] = req.tag;
      end else begin : g_next
        assign s_rem[k] = rem_q[k-1];
        assign s_nq[k]  = nq_q[k-1];
        assign s_den[k] = den_q[k-1];
        assign s_tag[k] = tag_q[k-1];
      end

      // shift in the next dividend bit, subtract when it fits
      assign trial[k] = {s_rem[k], s_nq[k][DIV_QW-1]};
      assign ge[k]    = trial[k] >= {1'b0, s_den[k]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= ge[k] ? DIV_DW'(trial[k] - {1'b0, s_den[k]}) : trial[k][DIV_DW-1:0];
          nq_q[k]  <= {s_nq[k][DIV_QW-2:0], ge[k]};
          tag_q[k] <= s_tag[k];
        end
      end

      if (k < DIV_QW - 1) begin : g_den
        always_ff @(posedge clk) begin
          if (en) begin
            den_q[k] <= s_den[k];
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DIV_QW-2:0], req.vld};
    end
  end

  assign rsp.vld = vld_q[DIV_QW-1];
  assign rsp.quo = nq_q[DIV_QW-1];
  assign rsp.tag = tag_q[DIV_QW-1];

endmodule

`default_nettype wire

>>> hw/rtl/depth_to_point_cloud.sv
// Top level: depth pixel to Q15.16 3-D point, fully pipelined.
// Depends on dtpc_pkg and dtpc_div.
//
//   port group   dir   handshake          payload
//   in_*         in    in_valid/in_stall  pixel_t (col, row, raw depth)
//   out_*        out   out_valid/out_stall point_t (x, y, z, valid flag)
//   cfg_*        in    cfg_we             cfg_index, cfg_data
//
// One pixel per cycle while the output is not stalled; the pipe is set by three 32-stage dividers
// in series (disparity, depth, then x/y in parallel) plus arithmetic stages.
// Reset clears valid bits and loads default calibration; data regs not reset.
// A stalled full output register freezes every stage at once; nothing drops.
`default_nettype none

module depth_to_point_cloud (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  dtpc_pkg::pixel_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output dtpc_pkg::point_t out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [47:0]      cfg_data
);
  import dtpc_pkg::*;

  // calibration registers
  logic [25:0]        pc, pr;
  logic [27:0]        fc, fr;
  logic signed [31:0] doff, dgain;
  logic signed [47:0] cu, cv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= 26'd20971520;
      pr    <= 26'd15728640;
      fc    <= 28'd37377997;
      fr    <= 28'd37377997;
      doff  <= '0;
      dgain <= 32'sd16777216;
      cu    <= '0;
      cv    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PRINCIPAL_COL:    pc    <= cfg_data[25:0];
        CFG_PRINCIPAL_ROW:    pr    <= cfg_data[25:0];
        CFG_FOCAL_COL:        fc    <= cfg_data[27:0];
        CFG_FOCAL_ROW:        fr    <= cfg_data[27:0];
        CFG_DISPARITY_OFFSET: doff  <= cfg_data[31:0];
        CFG_DISPARITY_GAIN:   dgain <= cfg_data[31:0];
        CFG_COL_SQ_COEFF:     cu    <= cfg_data[47:0];
        CFG_ROW_SQ_COEFF:     cv    <= cfg_data[47:0];
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  // no transfer is taken while reset holds the pipe empty
  assign in_stall = rst || !en;

  // ---------------- S1: input register, range checks
  logic   s1_vld, s1_ok;
  pixel_t s1_pix;
  logic   ok_in;

  assign ok_in = ({3'b0, in_data.pixel_col} < FRAME_WIDTH)
              && ({4'b0, in_data.pixel_row} < FRAME_HEIGHT)
              && (in_data.raw_depth_mm != '0)
              && (in_data.raw_depth_mm <= MAX_RANGE_MM);

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (en) s1_vld <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix <= in_data;
      s1_ok  <= ok_in;
    end
  end

  logic signed [26:0] s1_du, s1_dv;
  assign s1_du = $signed({1'b0, s1_pix.pixel_col, 16'b0}) - $signed({1'b0, pc});
  assign s1_dv = $signed({2'b0, s1_pix.pixel_row, 16'b0}) - $signed({1'b0, pr});

  // ---------------- disparity divider: d = K / r
  div_req_t dd_req;
  div_rsp_t dd_rsp;
  assign dd_req.vld = s1_vld;
  assign dd_req.rem = '0;
  assign dd_req.num = DISP_K16;
  assign dd_req.den = {40'b0, s1_pix.raw_depth_mm};
  assign dd_req.tag = {9'b0, s1_du, s1_dv, s1_ok};

  dtpc_div u_div_disp (.clk(clk), .rst(rst), .en(en), .req(dd_req), .rsp(dd_rsp));

  logic signed [26:0] dd_du, dd_dv;
  logic [25:0]        dd_du_mag, dd_dv_mag;
  logic [31:0]        gain_mag;
  assign dd_du     = dd_rsp.tag[54:28];
  assign dd_dv     = dd_rsp.tag[27:1];
  assign dd_du_mag = dd_du[26] ? 26'(-dd_du) : dd_du[25:0];
  assign dd_dv_mag = dd_dv[26] ? 26'(-dd_dv) : dd_dv[25:0];
  assign gain_mag  = dgain[31] ? 32'(-dgain) : 32'(dgain);

  // ---------------- S2: gain product, squared offsets
  logic               s2_vld, s2_ok;
  logic signed [26:0] s2_du, s2_dv;
  logic [63:0]        s2_gd;
  logic [51:0]        s2_sq_u, s2_sq_v;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ok   <= dd_rsp.tag[0];
      s2_du   <= dd_du;
      s2_dv   <= dd_dv;
      s2_gd   <= 64'(gain_mag) * 64'(dd_rsp.quo);
      s2_sq_u <= 52'(dd_du_mag) * 52'(dd_du_mag);
      s2_sq_v <= 52'(dd_dv_mag) * 52'(dd_dv_mag);
    end
  end

  // ---------------- S3: signed gain term, coefficient partial products
  logic [47:0] cu_mag, cv_mag;
  assign cu_mag = cu[47] ? 48'(-cu) : 48'(cu);
  assign cv_mag = cv[47] ? 48'(-cv) : 48'(cv);

  logic               s3_vld, s3_ok;
  logic signed [26:0] s3_du, s3_dv;
  logic signed [48:0] s3_gd;
  logic [49:0]        s3_u00, s3_u01, s3_u10, s3_u11;
  logic [49:0]        s3_v00, s3_v01, s3_v10, s3_v11;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ok  <= s2_ok;
      s3_du  <= s2_du;
      s3_dv  <= s2_dv;
      s3_gd  <= dgain[31] ? -$signed({1'b0, s2_gd[63:16]}) : $signed({1'b0, s2_gd[63:16]});
      s3_u00 <= 50'(cu_mag[23:0]) * 50'(s2_sq_u[25:0]);
      s3_u01 <= 50'(cu_mag[23:0]) * 50'(s2_sq_u[51:26]);
      s3_u10 <= 50'(cu_mag[47:24]) * 50'(s2_sq_u[25:0]);
      s3_u11 <= 50'(cu_mag[47:24]) * 50'(s2_sq_u[51:26]);
      s3_v00 <= 50'(cv_mag[23:0]) * 50'(s2_sq_v[25:0]);
      s3_v01 <= 50'(cv_mag[23:0]) * 50'(s2_sq_v[51:26]);
      s3_v10 <= 50'(cv_mag[47:24]) * 50'(s2_sq_v[25:0]);
      s3_v11 <= 50'(cv_mag[47:24]) * 50'(s2_sq_v[51:26]);
    end
  end

  // ---------------- S4: middle partial sums
  logic               s4_vld, s4_ok;
  logic signed [26:0] s4_du, s4_dv;
  logic signed [48:0] s4_gd;
  logic [49:0]        s4_u00, s4_u11, s4_v00, s4_v11;
  logic [52:0]        s4_umid, s4_vmid;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ok   <= s3_ok;
      s4_du   <= s3_du;
      s4_dv   <= s3_dv;
      s4_gd   <= s3_gd;
      s4_u00  <= s3_u00;
      s4_u11  <= s3_u11;
      s4_v00  <= s3_v00;
      s4_v11  <= s3_v11;
      s4_umid <= (53'(s3_u01) << 2) + 53'(s3_u10);
      s4_vmid <= (53'(s3_v01) << 2) + 53'(s3_v10);
    end
  end

  // ---------------- S5: full products >> 48, signed terms
  logic [99:0] u_full, v_full;
  assign u_full = 100'(s4_u00) + (100'(s4_umid) << 24) + (100'(s4_u11) << 50);
  assign v_full = 100'(s4_v00) + (100'(s4_vmid) << 24) + (100'(s4_v11) << 50);

  logic               s5_vld, s5_ok;
  logic signed [26:0] s5_du, s5_dv;
  logic signed [48:0] s5_gd;
  logic signed [52:0] s5_tu, s5_tv;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ok <= s4_ok;
      s5_du <= s4_du;
      s5_dv <= s4_dv;
      s5_gd <= s4_gd;
      s5_tu <= cu[47] ? -$signed({1'b0, u_full[99:48]}) : $signed({1'b0, u_full[99:48]});
      s5_tv <= cv[47] ? -$signed({1'b0, v_full[99:48]}) : $signed({1'b0, v_full[99:48]});
    end
  end

  // ---------------- S6: denominator sum
  logic               s6_vld, s6_ok;
  logic signed [26:0] s6_du, s6_dv;
  logic signed [55:0] s6_den;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ok  <= s5_ok;
      s6_du  <= s5_du;
      s6_dv  <= s5_dv;
      s6_den <= $signed({{16{doff[31]}}, doff, 8'b0})
              + $signed({{7{s5_gd[48]}}, s5_gd})
              + $signed({{3{s5_tu[52]}}, s5_tu})
              + $signed({{3{s5_tv[52]}}, s5_tv});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= dd_rsp.vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
    end
  end

  // ---------------- depth divider: z = C / den
  logic den_pos, z_sat_in;
  assign den_pos  = !s6_den[55] && (s6_den != '0);
  // quotient of 2^32 or more when the upper dividend part reaches den
  assign z_sat_in = {42'b0, BF_Q40[45:32]} >= s6_den;

  div_req_t zd_req;
  div_rsp_t zd_rsp;
  assign zd_req.vld = s6_vld;
  assign zd_req.rem = {42'b0, BF_Q40[45:32]};
  assign zd_req.num = BF_Q40[31:0];
  assign zd_req.den = s6_den;
  assign zd_req.tag = {8'b0, s6_du, s6_dv, s6_ok && den_pos, z_sat_in};

  dtpc_div u_div_depth (.clk(clk), .rst(rst), .en(en), .req(zd_req), .rsp(zd_rsp));

  // ---------------- S7: saturated z
  logic               s7_vld, s7_ok;
  logic signed [26:0] s7_du, s7_dv;
  logic [30:0]        s7_z;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_du <= zd_rsp.tag[55:29];
      s7_dv <= zd_rsp.tag[28:2];
      s7_ok <= zd_rsp.tag[1];
      s7_z  <= (zd_rsp.tag[0] || zd_rsp.quo[31]) ? S32_MAX : zd_rsp.quo[30:0];
    end
  end

  // ---------------- S8: offset times z
  logic [25:0] s7_du_mag, s7_dv_mag;
  assign s7_du_mag = s7_du[26] ? 26'(-s7_du) : s7_du[25:0];
  assign s7_dv_mag = s7_dv[26] ? 26'(-s7_dv) : s7_dv[25:0];

  logic        s8_vld, s8_ok, s8_sx, s8_sy;
  logic [30:0] s8_z;
  logic [56:0] s8_px, s8_py;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_ok <= s7_ok;
      s8_sx <= s7_du[26];
      s8_sy <= s7_dv[26];
      s8_z  <= s7_z;
      s8_px <= 57'(s7_du_mag) * 57'(s7_z);
      s8_py <= 57'(s7_dv_mag) * 57'(s7_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
      s8_vld <= 1'b0;
    end else if (en) begin
      s7_vld <= zd_rsp.vld;
      s8_vld <= s7_vld;
    end
  end

  // ---------------- coordinate dividers
  logic satx_in, saty_in;
  assign satx_in = {3'b0, s8_px[56:32]} >= fc;
  assign saty_in = {3'b0, s8_py[56:32]} >= fr;

  div_req_t xd_req, yd_req;
  div_rsp_t xd_rsp, yd_rsp;
  assign xd_req.vld = s8_vld;
  assign xd_req.rem = {31'b0, s8_px[56:32]};
  assign xd_req.num = s8_px[31:0];
  assign xd_req.den = {28'b0, fc};
  assign xd_req.tag = {29'b0, s8_z, s8_ok, s8_sx, satx_in, fc == '0};

  assign yd_req.vld = s8_vld;
  assign yd_req.rem = {31'b0, s8_py[56:32]};
  assign yd_req.num = s8_py[31:0];
  assign yd_req.den = {28'b0, fr};
  assign yd_req.tag = {61'b0, s8_sy, saty_in, fr == '0};

  dtpc_div u_div_x (.clk(clk), .rst(rst), .en(en), .req(xd_req), .rsp(xd_rsp));
  dtpc_div u_div_y (.clk(clk), .rst(rst), .en(en), .req(yd_req), .rsp(yd_rsp));

  function automatic logic [31:0] coord_sat(input logic [31:0] m, input logic neg,
                                             input logic sat, input logic fz);
    logic [31:0] lim;
    begin
      lim = m;
      if (fz) begin
        coord_sat = '0;
      end else if (!neg) begin
        coord_sat = (sat || m[31]) ? {1'b0, S32_MAX} : m;
      end else begin
        if (sat || (m[31] && (m[30:0] != '0))) lim = 32'h8000_0000;
        coord_sat = 32'(-lim);
      end
    end
  endfunction

  logic [31:0] x_fin, y_fin;
  assign x_fin = coord_sat(xd_rsp.quo, xd_rsp.tag[2], xd_rsp.tag[1], xd_rsp.tag[0]);
  assign y_fin = coord_sat(yd_rsp.quo, yd_rsp.tag[2], yd_rsp.tag[1], yd_rsp.tag[0]);

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= xd_rsp.vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (xd_rsp.tag[3]) begin
        out_data.point_x     <= x_fin;
        out_data.point_y     <= y_fin;
        out_data.point_z     <= {1'b0, xd_rsp.tag[34:4]};
        out_data.point_valid <= 1'b1;
      end else begin
        out_data <= '0;
      end
    end
  end

  // ---------------- checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.point_valid |->
      out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0)
    else $error("invalid point carries nonzero coordinates");

  a_z_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.point_valid |-> !out_data.point_z[31])
    else $error("valid point with negative depth");

  a_focal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fc == '0 && $stable(fc) |-> out_data.point_x == '0)
    else $error("zero column focal length gave nonzero x");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_vld)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> sim/depth_to_point_cloud_tb.sv
// Testbench for depth_to_point_cloud: random and directed pixels, with a scoreboard
// that predicts each back-projected point and compares it with the block's output.
// Depends on dtpc_pkg and the depth_to_point_cloud RTL.
`default_nettype none

module depth_to_point_cloud_tb;
  import dtpc_pkg::*;

  localparam int LATENCY = 105;

  class point_scoreboard;
    logic [25:0] p_col, p_row;
    logic [27:0] f_col, f_row;
    logic signed [31:0] d_off, d_gain;
    logic signed [47:0] u_coef, v_coef;
    point_t pending[$];
    int errors;

    function void reset_regs();
      p_col = 26'd20971520;
      p_row = 26'd15728640;
      f_col = 28'd37377997;
      f_row = 28'd37377997;
      d_off = '0;
      d_gain = 32'sd16777216;
      u_coef = '0;
      v_coef = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [47:0] val);
      case (idx)
        CFG_PRINCIPAL_COL: p_col = val[25:0];
        CFG_PRINCIPAL_ROW: p_row = val[25:0];
        CFG_FOCAL_COL: f_col = val[27:0];
        CFG_FOCAL_ROW: f_row = val[27:0];
        CFG_DISPARITY_OFFSET: d_off = val[31:0];
        CFG_DISPARITY_GAIN: d_gain = val[31:0];
        CFG_COL_SQ_COEFF: u_coef = val;
        default: v_coef = val;
      endcase
    endfunction

    // coefficient * offset^2 >> 48, truncated toward zero
    function logic signed [63:0] sq_term(logic signed [47:0] c, logic signed [63:0] off);
      logic [127:0] m;
      logic [63:0] om, cm;
      om = off < 0 ? -off : off;
      cm = c < 0 ? -64'(c) : 64'(c);
      m = (128'(cm) * 128'(om * om)) >> 48;
      return c < 0 ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    function logic [31:0] coord(logic signed [63:0] off, logic [63:0] z, logic [27:0] f);
      logic [63:0] m;
      if (f == 0) return '0;
      m = (off < 0 ? -off : off) * z / f;
      if (off >= 0) return m > 64'h7FFFFFFF ? 32'h7FFFFFFF : m[31:0];
      if (m > 64'h80000000) m = 64'h80000000;
      return -m[31:0];
    endfunction

    function void note_pixel(pixel_t px);
      point_t pt;
      logic [63:0] d, z, gm;
      logic signed [63:0] gd, du, dv, den;
      pt = '0;
      if (px.pixel_col < 640 && px.pixel_row < 480 && px.raw_depth_mm != 0 &&
          px.raw_depth_mm <= 5000) begin
        d = 64'(DISP_K16) / px.raw_depth_mm;
        gm = d_gain < 0 ? -64'(d_gain) : 64'(d_gain);
        gd = $signed((gm * d) >> 16);
        if (d_gain < 0) gd = -gd;
        du = $signed(64'(px.pixel_col) << 16) - $signed(64'(p_col));
        dv = $signed(64'(px.pixel_row) << 16) - $signed(64'(p_row));
        den = 64'(d_off) * 256 + gd + sq_term(u_coef, du) + sq_term(v_coef, dv);
        if (den > 0) begin
          z = 64'(BF_Q40) / den;
          if (z > 64'h7FFFFFFF) z = 64'h7FFFFFFF;
          pt.point_x = coord(du, z, f_col);
          pt.point_y = coord(dv, z, f_row);
          pt.point_z = z[31:0];
          pt.point_valid = 1'b1;
        end
      end
      pending.insert(pending.size(), pt);
    endfunction

    function void check_point(point_t got);
      point_t exp_pt;
      if (pending.size() == 0) begin
        $error("unexpected point %h", got);
        errors++;
        return;
      end
      exp_pt = pending.pop_front();
      if (got.point_x !== exp_pt.point_x) begin
        $error("point_x exp %h got %h", exp_pt.point_x, got.point_x); errors++;
      end
      if (got.point_y !== exp_pt.point_y) begin
        $error("point_y exp %h got %h", exp_pt.point_y, got.point_y); errors++;
      end
      if (got.point_z !== exp_pt.point_z) begin
        $error("point_z exp %h got %h", exp_pt.point_z, got.point_z); errors++;
      end
      if (got.point_valid !== exp_pt.point_valid) begin
        $error("point_valid exp %b got %b", exp_pt.point_valid, got.point_valid); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  pixel_t in_data = '0;
  logic out_valid, out_stall = 0;
  point_t out_data;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  point_scoreboard sb;
  bit hold_output = 0;
  int rx_hold = 0;

  depth_to_point_cloud uut (.*);

  always #5 clk = ~clk;

  function int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  task automatic send_pixel(pixel_t px);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(px);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [47:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function pixel_t rand_pixel(bit wild);
    pixel_t px;
    px.pixel_col = wild ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 639));
    px.pixel_row = wild ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 479));
    case ($urandom_range(0, 9))
      0: px.raw_depth_mm = 16'($urandom_range(0, 65535));
      1: px.raw_depth_mm = 0;
      default: px.raw_depth_mm = 16'($urandom_range(1, 5000));
    endcase
    return px;
  endfunction

  // receiver: random stalls, an occasional longer one, plus a long hold when requested
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_point(out_data);
    if (rx_hold > 0) rx_hold--;
    else if ($urandom_range(0, 59) == 0) rx_hold = $urandom_range(10, 40);
    if (hold_output || rx_hold > 0) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 9) < 3) && ($urandom_range(0, 3) != 0);
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes and every special case at reset calibration
    send_pixel('{0, 0, 1});
    send_pixel('{639, 479, 5000});
    send_pixel('{320, 240, 1000});
    send_pixel('{100, 100, 0});
    send_pixel('{100, 100, 5001});
    send_pixel('{100, 100, 65535});
    send_pixel('{640, 100, 1000});
    send_pixel('{1023, 511, 1000});
    send_pixel('{100, 480, 1000});
    send_pixel('{0, 479, 16'h5555});
    send_pixel('{10'h2AA, 9'h155, 16'h0AAA});
    drain();

    // zero focal lengths, negative gain: negative and zero denominators
    write_cfg(CFG_FOCAL_COL, 0);
    write_cfg(CFG_FOCAL_ROW, 0);
    send_pixel('{5, 7, 800});
    drain();
    write_cfg(CFG_DISPARITY_GAIN, 0);
    send_pixel('{5, 7, 800});
    drain();
    write_cfg(CFG_DISPARITY_GAIN, 48'hFFFF_FF00_0000);
    send_pixel('{5, 7, 800});
    drain();
    write_cfg(CFG_DISPARITY_OFFSET, 48'h0000_7FFF_FFFF);
    send_pixel('{600, 400, 300});
    drain();

    // extremes of every register
    write_cfg(CFG_PRINCIPAL_COL, 48'h3FF_FFFF);
    write_cfg(CFG_PRINCIPAL_ROW, 0);
    write_cfg(CFG_FOCAL_COL, 1);
    write_cfg(CFG_FOCAL_ROW, 48'hFFF_FFFF);
    write_cfg(CFG_DISPARITY_OFFSET, 1);
    write_cfg(CFG_DISPARITY_GAIN, 48'h7FFF_FFFF);
    write_cfg(CFG_COL_SQ_COEFF, 48'h7FFF_FFFF_FFFF);
    write_cfg(CFG_ROW_SQ_COEFF, 48'h8000_0000_0000);
    send_pixel('{0, 479, 1});
    send_pixel('{639, 0, 5000});
    send_pixel('{300, 200, 2500});
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      sb.reset_regs();
      write_cfg(CFG_PRINCIPAL_COL,
                48'($urandom_range(0, 639) << 16 | $urandom_range(0, 65535)));
      write_cfg(CFG_PRINCIPAL_ROW,
                48'($urandom_range(0, 479) << 16 | $urandom_range(0, 65535)));
      write_cfg(CFG_FOCAL_COL,
                48'($urandom_range(1, 1000) << 16 | $urandom_range(0, 65535)));
      write_cfg(CFG_FOCAL_ROW, phase == 3 ? 48'($urandom() & 28'hFFFFFFF) :
                48'($urandom_range(1, 1000) << 16));
      write_cfg(CFG_DISPARITY_OFFSET, {{16{1'b0}}, 32'($signed($urandom_range(0, 20000)) - 10000)});
      write_cfg(CFG_DISPARITY_GAIN, phase == 0 ? 48'h100_0000 :
                {16'b0, $urandom_range(32'h80_0000, 32'h180_0000)});
      write_cfg(CFG_COL_SQ_COEFF, phase[0] ? 48'({$urandom(), $urandom()}) :
                48'(int'($urandom_range(0, 4000)) - 2000));
      write_cfg(CFG_ROW_SQ_COEFF, phase[1] ? 48'({$urandom(), $urandom()}) :
                48'(int'($urandom_range(0, 4000)) - 2000));
      if (phase == 1) begin
        // long output hold while inputs keep coming, so the pipe backs up
        fork
          begin
            hold_output = 1;
            repeat (300) @(posedge clk);
            hold_output = 0;
          end
          for (int i = 0; i < 150; i++) send_pixel(rand_pixel(0));
        join
      end
      for (int i = 0; i < 60; i++) send_pixel(rand_pixel($urandom_range(0, 9) == 0));
      drain();
    end

    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire
